// ----- design/sfd_pkg.sv -----
// Shared types and constants for the signature frame deframer.
// Used by every module of the block; depends on nothing else.
package sfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  localparam logic [WordW-1:0] StartMarkerRst = 16'd16018;
  localparam logic [WordW-1:0] EndMarkerRst   = 16'd16108;
  localparam logic [WordW-1:0] MaxLengthRst   = 16'd8192;

  // Shortest legal frame: two markers, length and id, no payload.
  localparam logic [WordW-1:0] MinFrame = 16'd8;
  // Header bytes before the body: start marker, length and id; length minus this is the body.
  localparam logic [WordW-1:0] HeaderLen = 16'd6;

  typedef enum logic [1:0] {
    REG_START_MARKER = 2'd0,
    REG_END_MARKER   = 2'd1,
    REG_MAX_LENGTH   = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    KIND_PAYLOAD    = 3'd0,
    KIND_GOOD       = 3'd1,
    KIND_BAD_START  = 3'd2,
    KIND_BAD_LENGTH = 3'd3,
    KIND_BAD_END    = 3'd4
  } kind_t;

  typedef struct packed {
    logic [WordW-1:0] start_marker;
    logic [WordW-1:0] end_marker;
    logic [WordW-1:0] max_length;
  } cfg_t;

  typedef struct packed {
    kind_t            kind;
    logic [ByteW-1:0] payload_byte;
    logic [WordW-1:0] packet_id;
    logic [WordW-1:0] frame_length;
    logic             last;
  } res_t;

endpackage

// ----- design/sfd_cfg_regs.sv -----
// APB-style configuration registers of the frame deframer.
// Depends on sfd_pkg for the register map and the cfg_t bundle.
module sfd_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfd_pkg::AddrW-1:0]  paddr,
  input  logic [sfd_pkg::DataW-1:0]  pwdata,
  output logic [sfd_pkg::DataW-1:0]  prdata,
  output sfd_pkg::cfg_t              cfg
);
  import sfd_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[AddrW-1:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_marker <= StartMarkerRst;
      cfg_r.end_marker   <= EndMarkerRst;
      cfg_r.max_length   <= MaxLengthRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_START_MARKER: cfg_r.start_marker <= pwdata[WordW-1:0];
        REG_END_MARKER:   cfg_r.end_marker   <= pwdata[WordW-1:0];
        REG_MAX_LENGTH:   cfg_r.max_length   <= pwdata[WordW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_START_MARKER: prdata[WordW-1:0] = cfg_r.start_marker;
      REG_END_MARKER:   prdata[WordW-1:0] = cfg_r.end_marker;
      REG_MAX_LENGTH:   prdata[WordW-1:0] = cfg_r.max_length;
      default:          prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ----- design/sfd_parser.sv -----
// Frame parser state machine: header, payload and end-marker handling.
// Depends on sfd_pkg; produces at most one result per accepted byte.
module sfd_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sfd_pkg::cfg_t             cfg,
  input  logic                      in_fire,
  input  logic [sfd_pkg::ByteW-1:0] rx_byte,
  output logic                      res_valid,
  output sfd_pkg::res_t             res
);
  import sfd_pkg::*;

  typedef enum logic [2:0] {
    PH_START_LO = 3'd0,
    PH_START_HI = 3'd1,
    PH_LEN_LO   = 3'd2,
    PH_LEN_HI   = 3'd3,
    PH_ID_LO    = 3'd4,
    PH_ID_HI    = 3'd5,
    PH_BODY     = 3'd6
  } phase_t;

  phase_t           phase_r,       phase_nxt;
  logic [WordW-1:0] byte_count_r,  byte_count_nxt;
  logic [ByteW-1:0] marker_low_r,  marker_low_nxt;
  logic [WordW-1:0] length_held_r, length_held_nxt;
  logic [WordW-1:0] id_held_r,     id_held_nxt;
  logic [WordW-1:0] word;
  logic             hit;

  assign word = {rx_byte, marker_low_r};

  always_comb begin
    phase_nxt       = phase_r;
    byte_count_nxt  = byte_count_r;
    marker_low_nxt  = marker_low_r;
    length_held_nxt = length_held_r;
    id_held_nxt     = id_held_r;
    hit             = 1'b0;
    res             = '0;
    res.kind        = KIND_PAYLOAD;
    unique case (phase_r)
      PH_START_HI: begin
        if (word != cfg.start_marker) begin
          phase_nxt = PH_START_LO;
          hit       = 1'b1;
          res.kind  = KIND_BAD_START;
          res.last  = 1'b1;
        end else begin
          phase_nxt = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        length_held_nxt = {{(WordW-ByteW){1'b0}}, rx_byte};
        phase_nxt       = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_held_nxt = {rx_byte, length_held_r[ByteW-1:0]};
        if (length_held_nxt < MinFrame || length_held_nxt > cfg.max_length) begin
          phase_nxt        = PH_START_LO;
          hit              = 1'b1;
          res.kind         = KIND_BAD_LENGTH;
          res.frame_length = length_held_nxt;
          res.last         = 1'b1;
        end else begin
          phase_nxt = PH_ID_LO;
        end
      end
      PH_ID_LO: begin
        id_held_nxt = {{(WordW-ByteW){1'b0}}, rx_byte};
        phase_nxt   = PH_ID_HI;
      end
      PH_ID_HI: begin
        id_held_nxt    = {rx_byte, id_held_r[ByteW-1:0]};
        byte_count_nxt = length_held_r - HeaderLen;
        phase_nxt      = PH_BODY;
      end
      PH_BODY: begin
        if (byte_count_r > 16'd2) begin
          byte_count_nxt   = byte_count_r - 16'd1;
          hit              = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = rx_byte;
          res.packet_id    = id_held_r;
          res.frame_length = length_held_r;
        end else if (byte_count_r == 16'd2) begin
          marker_low_nxt = rx_byte;
          byte_count_nxt = 16'd1;
        end else begin
          byte_count_nxt   = '0;
          phase_nxt        = PH_START_LO;
          hit              = 1'b1;
          res.kind         = (word == cfg.end_marker) ? KIND_GOOD : KIND_BAD_END;
          res.packet_id    = id_held_r;
          res.frame_length = length_held_r;
          res.last         = 1'b1;
        end
      end
      default: begin
        // Waiting for the first start byte; also recovers from any unused code.
        marker_low_nxt  = rx_byte;
        length_held_nxt = '0;
        id_held_nxt     = '0;
        byte_count_nxt  = '0;
        phase_nxt       = PH_START_HI;
      end
    endcase
  end

  assign res_valid = in_fire && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_START_LO;
      byte_count_r  <= '0;
      marker_low_r  <= '0;
      length_held_r <= '0;
      id_held_r     <= '0;
    end else if (in_fire) begin
      phase_r       <= phase_nxt;
      byte_count_r  <= byte_count_nxt;
      marker_low_r  <= marker_low_nxt;
      length_held_r <= length_held_nxt;
      id_held_r     <= id_held_nxt;
    end
  end

  // The body always has at least one end-marker byte still due.
  a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (byte_count_r != '0))
    else $error("body phase with zero byte count");

  // Payload results come only from the body and never close a frame.
  a_payload_src: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == KIND_PAYLOAD) |-> (phase_r == PH_BODY && !res.last))
    else $error("payload result outside body");

endmodule

// ----- design/sfd_out_stage.sv -----
// Result register with a skid entry, so input is taken while a result waits.
// Depends on sfd_pkg for the res_t bundle.
module sfd_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  input  sfd_pkg::res_t res,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output sfd_pkg::res_t out_res
);
  import sfd_pkg::*;

  logic out_valid_r;
  logic skid_valid_r;
  res_t out_res_r;
  res_t skid_r;
  logic out_take;

  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_take) begin
        out_valid_r  <= skid_valid_r || res_valid;
        skid_valid_r <= 1'b0;
      end else if (res_valid) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_res_r <= skid_valid_r ? skid_r : res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // The skid entry is only used behind a waiting result.
  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result while the output is empty");

  // A drained skid entry moves into the output register.
  a_skid_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> (out_valid_r && !skid_valid_r))
    else $error("skid entry lost on drain");

endmodule

// ----- design/signature_frame_deframer_top.sv -----
// Signature frame deframer: parses marker/length/id framed byte streams.
// Each result is registered in the output stage (its skid entry while the output register waits).
// Throughput: one byte per cycle; in_stall rises only when both the output register
// and its skid entry hold results that the sink has not taken.
// Reset (rst_n, synchronous): the parser waits for a start byte, no result is
// pending, and the registers return to 16018, 16108 and 8192.
module signature_frame_deframer_top (
  input  logic                      clk,
  input  logic                      rst_n,
  // Configuration port.
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sfd_pkg::AddrW-1:0] paddr,
  input  logic [sfd_pkg::DataW-1:0] pwdata,
  output logic [sfd_pkg::DataW-1:0] prdata,
  output logic                      pready,
  // Received byte stream, one item per byte.
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [sfd_pkg::ByteW-1:0] in_rx_byte,
  // Result items.
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                out_kind,
  output logic [sfd_pkg::ByteW-1:0] out_payload_byte,
  output logic [sfd_pkg::WordW-1:0] out_packet_id,
  output logic [sfd_pkg::WordW-1:0] out_frame_length,
  output logic                      out_last
);
  import sfd_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t out_res;
  logic res_valid;
  logic full;
  logic in_fire;

  // The configuration port never waits.
  assign pready = 1'b1;

  // An item is taken whenever the skid entry is free, so a result waiting in
  // the output register does not hold back the byte stream.
  assign in_stall = full;
  assign in_fire  = in_valid && !full;

  sfd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // The whole per-byte decision is made in one pass from the parser state
  // and the incoming byte; the result lands in the output stage below.
  sfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_fire   (in_fire),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  sfd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_payload_byte = out_res.payload_byte;
  assign out_packet_id    = out_res.packet_id;
  assign out_frame_length = out_res.frame_length;
  assign out_last         = out_res.last;

endmodule

// ----- tb/signature_frame_deframer_top_test.sv -----
// Self-checking testbench for signature_frame_deframer_top: byte streams of framed packets
// are pushed in and every result item is checked against a built-in frame parser model.
// Depends on sfd_pkg and the RTL of signature_frame_deframer_top only.
module signature_frame_deframer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sfd_pkg::*;

  // Parser position within a frame, as the model tracks it.
  typedef enum logic [2:0] {
    P_START_LO = 3'd0,
    P_START_HI = 3'd1,
    P_LEN_LO   = 3'd2,
    P_LEN_HI   = 3'd3,
    P_ID_LO    = 3'd4,
    P_ID_HI    = 3'd5,
    P_BODY     = 3'd6
  } parse_phase_t;

  // The model keeps its own copy of the registers and the parser state. Every accepted
  // byte is fed to take_byte, which queues the result item that byte should produce.
  // check_result compares each result item leaving the block with the oldest queued one.
  class frame_predictor;
    logic [WordW-1:0] start_marker;
    logic [WordW-1:0] end_marker;
    logic [WordW-1:0] max_length;
    parse_phase_t     phase;
    logic [WordW-1:0] byte_count;
    logic [ByteW-1:0] marker_low;
    logic [WordW-1:0] length_held;
    logic [WordW-1:0] id_held;
    res_t             expected_results[$];
    int unsigned      errors;

    function new();
      start_marker = StartMarkerRst;
      end_marker   = EndMarkerRst;
      max_length   = MaxLengthRst;
      phase        = P_START_LO;
      byte_count   = '0;
      marker_low   = '0;
      length_held  = '0;
      id_held      = '0;
      errors       = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [WordW-1:0] value);
      case (idx)
        REG_START_MARKER: start_marker = value;
        REG_END_MARKER:   end_marker = value;
        REG_MAX_LENGTH:   max_length = value;
        default: ;
      endcase
    endfunction

    function void queue_result(kind_t kind, logic [ByteW-1:0] data, logic [WordW-1:0] pid,
                               logic [WordW-1:0] flen, logic last);
      res_t r;
      r.kind         = kind;
      r.payload_byte = data;
      r.packet_id    = pid;
      r.frame_length = flen;
      r.last         = last;
      expected_results.push_back(r);
    endfunction

    function void take_byte(logic [ByteW-1:0] b);
      logic [WordW-1:0] word;
      word = {b, marker_low};
      case (phase)
        P_START_HI: begin
          if (word != start_marker) begin
            phase = P_START_LO;
            queue_result(KIND_BAD_START, '0, '0, '0, 1'b1);
          end else begin
            phase = P_LEN_LO;
          end
        end
        P_LEN_LO: begin
          length_held = {8'h00, b};
          phase = P_LEN_HI;
        end
        P_LEN_HI: begin
          length_held = {b, length_held[7:0]};
          if (length_held < MinFrame || length_held > max_length) begin
            phase = P_START_LO;
            queue_result(KIND_BAD_LENGTH, '0, '0, length_held, 1'b1);
          end else begin
            phase = P_ID_LO;
          end
        end
        P_ID_LO: begin
          id_held = {8'h00, b};
          phase = P_ID_HI;
        end
        P_ID_HI: begin
          id_held = {b, id_held[7:0]};
          // The body count covers the payload and both end-marker bytes.
          byte_count = length_held - HeaderLen;
          phase = P_BODY;
        end
        P_BODY: begin
          if (byte_count > 16'd2) begin
            byte_count = byte_count - 16'd1;
            queue_result(KIND_PAYLOAD, b, id_held, length_held, 1'b0);
          end else if (byte_count == 16'd2) begin
            marker_low = b;
            byte_count = 16'd1;
          end else begin
            byte_count = '0;
            phase = P_START_LO;
            queue_result((word == end_marker) ? KIND_GOOD : KIND_BAD_END, '0, id_held,
                         length_held, 1'b1);
          end
        end
        default: begin
          marker_low  = b;
          length_held = '0;
          id_held     = '0;
          byte_count  = '0;
          phase       = P_START_HI;
        end
      endcase
    endfunction

    function void compare_field(string field, logic [WordW-1:0] want, logic [WordW-1:0] got);
      if (got !== want) begin
        if (errors < 200)
          $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [2:0] kind, logic [ByteW-1:0] data,
                               logic [WordW-1:0] pid, logic [WordW-1:0] flen, logic last);
      res_t want;
      if (expected_results.size() == 0) begin
        if (errors < 200)
          $display("%0t ns: unexpected result, expected none, actual kind %0d id %h len %h",
                   $time, kind, pid, flen);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("kind", 16'(want.kind), 16'(kind));
      compare_field("payload_byte", 16'(want.payload_byte), 16'(data));
      compare_field("packet_id", want.packet_id, pid);
      compare_field("frame_length", want.frame_length, flen);
      compare_field("last", 16'(want.last), 16'(last));
    endfunction

    function int unsigned outstanding();
      return expected_results.size();
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ByteW-1:0]  in_rx_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        out_kind;
  logic [ByteW-1:0]  out_payload_byte;
  logic [WordW-1:0]  out_packet_id;
  logic [WordW-1:0]  out_frame_length;
  logic              out_last;

  frame_predictor predictor = new();

  // Sender burst bookkeeping and the receiver's stall pattern state.
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_run = 0;

  // Bytes of the frame currently being assembled by the stimulus generator.
  logic [ByteW-1:0] frame_q[$];

  signature_frame_deframer_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_packet_id    (out_packet_id),
    .out_frame_length (out_frame_length),
    .out_last         (out_last)
  );

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Both handshakes are sampled at the rising edge, where the values seen are the ones
  // that were stable before the edge. The byte is noted before the result is checked so
  // that the order holds even if a result came out in the same cycle as its byte.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        predictor.take_byte(in_rx_byte);
      if (out_valid && !out_stall)
        predictor.check_result(out_kind, out_payload_byte, out_packet_id, out_frame_length,
                               out_last);
    end
  end

  // The receiver switches between stretches of no stalling, light stalling and heavy
  // stalling. Heavy stalling fills the output skid entry and pushes back on the input.
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_run = $urandom_range(8, 64);
    end
    stall_run--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Offers one byte and returns at the edge where it is taken. The sender works in bursts;
  // at the start of a new burst it may first drop valid for a few cycles. Valid is never
  // lowered and raised in the same step, so a burst carries straight on between bytes.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // Waits until every expected result item has come out, then lets a few more cycles pass
  // so that a byte still inside the block cannot produce a late result unseen. The check
  // repeats in case a byte noted in the last cycle added an expectation.
  task automatic drain();
    in_valid <= 1'b0;
    do begin
      while (predictor.outstanding() != 0) @(posedge clk);
      repeat (8) @(posedge clk);
    end while (predictor.outstanding() != 0);
  endtask

  // One write transfer immediately followed by a read of the same register. The select
  // stays high across the two transfers; data is sampled at the edge that ends the access.
  // The port then idles before the next transfer may start.
  task automatic write_reg(input reg_idx_t idx, input logic [WordW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    predictor.set_reg(idx, value);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {16'h0000, value}) begin
      $display("%0t ns: register %s readback mismatch, expected %h, actual %h", $time,
               idx.name(), {16'h0000, value}, prdata);
      predictor.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void push_word(logic [WordW-1:0] w);
    frame_q.push_back(w[7:0]);
    frame_q.push_back(w[15:8]);
  endfunction

  // Random stimulus: mostly well-formed frames with random ids, lengths and payload, the
  // rest wrong start markers, rejected lengths, wrong end markers and short bursts of
  // noise. Noise comes in pairs of bytes so that the parser tends to fall back in step.
  // A frame with a bad start or a bad length is cut off where the parser gives up on it.
  task automatic send_random_frames(input int unsigned budget);
    int unsigned sent;
    int unsigned pick;
    int unsigned top;
    logic [WordW-1:0] marker;
    logic [WordW-1:0] len;
    sent = 0;
    while (sent < budget) begin
      frame_q = {};
      pick = $urandom_range(0, 99);
      marker = predictor.start_marker;
      if (pick < 8) begin
        repeat (2 * $urandom_range(1, 3)) frame_q.push_back(8'($urandom));
      end else if (pick < 16) begin
        push_word(marker ^ 16'($urandom_range(1, 65535)));
      end else if (pick < 26 || predictor.max_length < MinFrame) begin
        // With a length cap below the minimum every length is refused.
        if (predictor.max_length < MinFrame)
          len = 16'($urandom);
        else if (predictor.max_length == 16'hFFFF || $urandom_range(0, 1) == 0)
          len = 16'($urandom_range(0, MinFrame - 1));
        else
          len = 16'($urandom_range(predictor.max_length + 1, 65535));
        push_word(marker);
        push_word(len);
      end else begin
        // Most frames are short; a few carry a longer payload.
        top = ($urandom_range(0, 9) == 0) ? 300 : 40;
        if (top > predictor.max_length) top = predictor.max_length;
        len = 16'($urandom_range(MinFrame, top));
        push_word(marker);
        push_word(len);
        push_word(16'($urandom));
        repeat (len - MinFrame) frame_q.push_back(8'($urandom));
        if ($urandom_range(0, 99) < 15)
          push_word(predictor.end_marker ^ 16'($urandom_range(1, 65535)));
        else
          push_word(predictor.end_marker);
      end
      foreach (frame_q[i]) send_byte(frame_q[i]);
      sent += frame_q.size();
    end
  endtask

  // Registers are only rewritten with the block idle: the input is held off and every
  // expected result has been taken before the writes start.
  task automatic run_phase(input logic [WordW-1:0] start_word, input logic [WordW-1:0] end_word,
                           input logic [WordW-1:0] length_cap, input int unsigned budget);
    drain();
    write_reg(REG_START_MARKER, start_word);
    write_reg(REG_END_MARKER, end_word);
    write_reg(REG_MAX_LENGTH, length_cap);
    send_random_frames(budget);
  endtask

  initial begin
    logic [ByteW-1:0] directed_q[$];
    // Directed bytes under the reset settings (start 3E92, end 3EEC, cap 8192):
    //   a minimum-length frame with a good end and no payload,
    //   a frame with id FFFF and payload bytes 00 and FF whose end marker is swapped,
    //   a swapped start marker,
    //   a length one below the minimum, and a length one above the cap.
    directed_q = '{
      8'h92, 8'h3E, 8'h08, 8'h00, 8'h34, 8'h12, 8'hEC, 8'h3E,
      8'h92, 8'h3E, 8'h0A, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h3E, 8'hEC,
      8'h3E, 8'h92,
      8'h92, 8'h3E, 8'h07, 8'h00,
      8'h92, 8'h3E, 8'h01, 8'h20
    };
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_q[i]) send_byte(directed_q[i]);

    // Settings run from the extremes (zero and all-ones markers, a cap of exactly the
    // minimum, the widest cap, caps below the minimum) to random ones, ending with the reset cap.
    run_phase(16'h0000, 16'hFFFF, MinFrame, 300);
    run_phase(16'hFFFF, 16'h0000, 16'hFFFF, 400);
    run_phase(16'($urandom), 16'($urandom), MinFrame - 16'd1, 150);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom_range(9, 120)), 400);
    run_phase(16'($urandom), 16'($urandom), 16'h0000, 100);
    run_phase(16'($urandom), 16'($urandom), MaxLengthRst, 400);
    drain();

    if (predictor.errors == 0)
      $display("signature_frame_deframer_top verification clean");
    else
      $display("signature_frame_deframer_top verification failed");
    $finish;
  end

  // A hang on either handshake ends the run here, far beyond any correct run's length.
  initial begin
    #(5_000_000);
    $display("signature_frame_deframer_top verification failed");
    $finish;
  end

endmodule
